>>> hw/rtl/nrtp_pkg.sv
// Package for the nested region time profiler.
// Holds request and result codes, blend factors and memory word layouts.
// Used by nrtp_if and the top level.
package nrtp_pkg;

    typedef logic [5:0] t_slot;

    localparam logic [2:0] REQ_BEGIN  = 3'd0;
    localparam logic [2:0] REQ_ENTER  = 3'd1;
    localparam logic [2:0] REQ_LEAVE  = 3'd2;
    localparam logic [2:0] REQ_RECORD = 3'd3;
    localparam logic [2:0] REQ_END    = 3'd4;

    localparam logic [1:0] KIND_ENTER_OK  = 2'd0;
    localparam logic [1:0] KIND_ENTER_NO  = 2'd1;
    localparam logic [1:0] KIND_REPORT    = 2'd2;
    localparam logic [1:0] KIND_SUMMARY   = 2'd3;

    localparam logic [7:0] F_FRAME = 8'd123;
    localparam logic [7:0] F_UP    = 8'd205;
    localparam logic [7:0] F_DOWN  = 8'd102;

    typedef struct packed {
        logic [31:0] total;
        logic [31:0] self_t;
        logic [15:0] calls;
    } t_cur;

    typedef struct packed {
        logic [31:0] avg_total;
        logic [31:0] avg_self;
        logic [31:0] peak_total;
        logic [31:0] peak_self;
    } t_hist;

    typedef struct packed {
        logic [1:0]  item_kind;
        t_slot       stage_slot;
        logic [15:0] stage_id;
        logic [31:0] total_last;
        logic [31:0] self_last;
        logic [31:0] total_avg;
        logic [31:0] self_avg;
        logic [31:0] total_max;
        logic [31:0] self_max;
        logic [31:0] count_value;
        logic        slow_frame;
        logic        last_result;
    } t_result;

endpackage

>>> hw/rtl/nrtp_if.sv
// Channel interfaces of the nested region time profiler.
// Depends on nrtp_pkg for the stage slot type of the result channel.
interface nrtp_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [15:0] stage_tag;
    logic [31:0] elapsed_time;
    modport source(output valid, req_type, stage_tag, elapsed_time, input ready);
    modport sink(input valid, req_type, stage_tag, elapsed_time, output ready);
endinterface

interface nrtp_res_if;
    logic                valid;
    logic                ready;
    logic [1:0]          item_kind;
    nrtp_pkg::t_slot     stage_slot;
    logic [15:0]         stage_id;
    logic [31:0]         total_last;
    logic [31:0]         self_last;
    logic [31:0]         total_avg;
    logic [31:0]         self_avg;
    logic [31:0]         total_max;
    logic [31:0]         self_max;
    logic [31:0]         count_value;
    logic                slow_frame;
    logic                last_result;
    modport source(output valid, item_kind, stage_slot, stage_id, total_last, self_last,
                   total_avg, self_avg, total_max, self_max, count_value, slow_frame,
                   last_result, input ready);
    modport sink(input valid, item_kind, stage_slot, stage_id, total_last, self_last,
                 total_avg, self_avg, total_max, self_max, count_value, slow_frame,
                 last_result, output ready);
endinterface

>>> hw/rtl/nested_region_time_profiler_top.sv
// Nested region time profiler, top level.
// Sequencer over tag, stage, history and region stack memories (nrtp_ram),
// with nrtp_blend for averages. Depends on nrtp_pkg and nrtp_if.
//
// Events enter on i_req (valid/ready); results leave on o_res (valid/ready).
// Configuration registers are written through i_cfg_we, i_cfg_idx, i_cfg_data:
// index 0 is the spike threshold, 1 the cooldown. The user must write them only
// while the block is idle; the block itself does not enforce this. One event is
// worked on at a time; i_req.ready is high only between events. Tag lookup reads
// the tag memory one slot at a time, a read state and a compare state per slot,
// for enter and record. Leave with an open region goes through a stack read, a
// stage read, then the stage write and, with an enclosing region, the parent
// write. Begin frame clears the stage statistics in a sweep over the known stages.
// End frame sends one stage report per memory read pair, then the frame summary marked as the last transaction.
// A finished result waits in the output register while the next event is
// accepted; a stalled receiver holds the sequencer only when it has a new
// result to place. Reset empties the tag table, the region stack and all
// frame statistics and restores the register defaults.
module nested_region_time_profiler_top #(
    parameter int MAX_STAGES = 32,
    parameter int MAX_DEPTH  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nrtp_req_if.sink    i_req,
    nrtp_res_if.source  o_res,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    localparam int SW = $clog2(MAX_STAGES + 1);
    localparam int IW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int KW = IW + 32;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLR    = 4'd1;
    localparam logic [3:0] S_SRD    = 4'd2;
    localparam logic [3:0] S_SCMP   = 4'd3;
    localparam logic [3:0] S_FOUND  = 4'd4;
    localparam logic [3:0] S_POPD   = 4'd5;
    localparam logic [3:0] S_CHG    = 4'd6;
    localparam logic [3:0] S_EFST   = 4'd7;
    localparam logic [3:0] S_EFRD   = 4'd8;
    localparam logic [3:0] S_EFCALC = 4'd9;
    localparam logic [3:0] S_EFSUM  = 4'd10;

    localparam logic [SW-1:0] SLOT_NONE = SW'(MAX_STAGES);

    logic [3:0]        r_state, n_state;
    logic [2:0]        r_req, n_req;
    logic [15:0]       r_tag, n_tag;
    logic [31:0]       r_t, n_t;
    logic [SW-1:0]     r_idx, n_idx;
    logic [SW-1:0]     r_slot, n_slot;
    logic [SW-1:0]     r_count, n_count;
    logic [DW-1:0]     r_depth, n_depth;
    logic [31:0]       r_chg_t, n_chg_t;
    logic [31:0]       r_chg_s, n_chg_s;
    logic              r_par, n_par;
    logic [31:0]       r_fn, n_fn;
    logic [31:0]       r_favg, n_favg;
    logic [31:0]       r_fpeak, n_fpeak;
    logic [31:0]       r_lsf, n_lsf;
    logic [31:0]       r_thr, n_thr;
    logic [15:0]       r_cool, n_cool;
    logic              r_first, n_first;
    logic [SW-1:0]     r_hs, n_hs;
    logic [SW-1:0]     r_hi, n_hi;
    logic [31:0]       r_hs_t, n_hs_t;
    logic [31:0]       r_hi_t, n_hi_t;
    logic              r_out_valid, n_out_valid;
    nrtp_pkg::t_result r_out, n_out;

    logic              w_tag_we;
    logic [IW-1:0]     w_tag_waddr, w_tag_raddr;
    logic [15:0]       w_tag_wdata, w_tag_rdata;
    logic              w_cur_we;
    logic [IW-1:0]     w_cur_waddr, w_cur_raddr;
    nrtp_pkg::t_cur    w_cur_wdata, w_cur_rdata;
    logic              w_hist_we;
    logic [IW-1:0]     w_hist_waddr, w_hist_raddr;
    nrtp_pkg::t_hist   w_hist_wdata, w_hist_rdata;
    logic              w_stk_we;
    logic [AW-1:0]     w_stk_waddr, w_stk_raddr;
    logic [KW-1:0]     w_stk_wdata, w_stk_rdata;

    logic              w_out_free;
    logic [31:0]       w_bl_t, w_bl_s, w_bl_f;
    logic [7:0]        w_f_t, w_f_s;
    logic [31:0]       w_child, w_sum, w_pchild;
    logic [32:0]       w_add_t, w_add_s, w_add_p;
    logic              w_slow, w_flag;
    nrtp_pkg::t_hist   w_hist_new;

    nrtp_ram #(.W(16), .D(MAX_STAGES)) u_tag_ram (
        .i_clk(i_clk), .i_we(w_tag_we), .i_waddr(w_tag_waddr), .i_wdata(w_tag_wdata),
        .i_raddr(w_tag_raddr), .o_rdata(w_tag_rdata)
    );
    nrtp_ram #(.W($bits(nrtp_pkg::t_cur)), .D(MAX_STAGES)) u_cur_ram (
        .i_clk(i_clk), .i_we(w_cur_we), .i_waddr(w_cur_waddr), .i_wdata(w_cur_wdata),
        .i_raddr(w_cur_raddr), .o_rdata(w_cur_rdata)
    );
    nrtp_ram #(.W($bits(nrtp_pkg::t_hist)), .D(MAX_STAGES)) u_hist_ram (
        .i_clk(i_clk), .i_we(w_hist_we), .i_waddr(w_hist_waddr), .i_wdata(w_hist_wdata),
        .i_raddr(w_hist_raddr), .o_rdata(w_hist_rdata)
    );
    nrtp_ram #(.W(KW), .D(MAX_DEPTH)) u_stk_ram (
        .i_clk(i_clk), .i_we(w_stk_we), .i_waddr(w_stk_waddr), .i_wdata(w_stk_wdata),
        .i_raddr(w_stk_raddr), .o_rdata(w_stk_rdata)
    );

    assign w_f_t = (w_cur_rdata.total > w_hist_rdata.avg_total) ?
                   nrtp_pkg::F_UP : nrtp_pkg::F_DOWN;
    assign w_f_s = (w_cur_rdata.self_t > w_hist_rdata.avg_self) ?
                   nrtp_pkg::F_UP : nrtp_pkg::F_DOWN;

    nrtp_blend u_bl_t (.i_cur(w_hist_rdata.avg_total), .i_tgt(w_cur_rdata.total),
                       .i_f(w_f_t), .o_avg(w_bl_t));
    nrtp_blend u_bl_s (.i_cur(w_hist_rdata.avg_self), .i_tgt(w_cur_rdata.self_t),
                       .i_f(w_f_s), .o_avg(w_bl_s));
    nrtp_blend u_bl_f (.i_cur(r_favg), .i_tgt(r_t), .i_f(nrtp_pkg::F_FRAME), .o_avg(w_bl_f));

    assign w_out_free = !r_out_valid || o_res.ready;
    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        w_child = w_stk_rdata[31:0];
        w_add_t = {1'b0, w_cur_rdata.total} + {1'b0, r_chg_t};
        w_add_s = {1'b0, w_cur_rdata.self_t} + {1'b0, r_chg_s};
        w_add_p = {1'b0, w_child} + {1'b0, r_t};
        w_sum = w_add_p[32] ? 32'hFFFF_FFFF : w_add_p[31:0];
        w_pchild = (r_t > w_child) ? (r_t - w_child) : 32'd0;
        w_hist_new.avg_total = r_first ? w_cur_rdata.total : w_bl_t;
        w_hist_new.avg_self = r_first ? w_cur_rdata.self_t : w_bl_s;
        w_hist_new.peak_total = (w_cur_rdata.total > w_hist_rdata.peak_total) ?
                                w_cur_rdata.total : w_hist_rdata.peak_total;
        w_hist_new.peak_self = (w_cur_rdata.self_t > w_hist_rdata.peak_self) ?
                               w_cur_rdata.self_t : w_hist_rdata.peak_self;
        w_slow = (r_t >= r_thr) || (r_hs_t >= r_thr) || (r_hi_t >= r_thr);
        w_flag = w_slow && ((r_lsf == 32'd0) || ((r_fn - r_lsf) >= {16'd0, r_cool}));
    end

    always_comb begin
        n_state = r_state;
        n_req = r_req;
        n_tag = r_tag;
        n_t = r_t;
        n_idx = r_idx;
        n_slot = r_slot;
        n_count = r_count;
        n_depth = r_depth;
        n_chg_t = r_chg_t;
        n_chg_s = r_chg_s;
        n_par = r_par;
        n_fn = r_fn;
        n_favg = r_favg;
        n_fpeak = r_fpeak;
        n_lsf = r_lsf;
        n_thr = r_thr;
        n_cool = r_cool;
        n_first = r_first;
        n_hs = r_hs;
        n_hi = r_hi;
        n_hs_t = r_hs_t;
        n_hi_t = r_hi_t;
        n_out = r_out;
        n_out_valid = r_out_valid && !o_res.ready;

        w_tag_we = 1'b0;
        w_tag_waddr = IW'(r_count);
        w_tag_wdata = r_tag;
        w_tag_raddr = IW'(r_idx);
        w_cur_we = 1'b0;
        w_cur_waddr = IW'(r_slot);
        w_cur_wdata = '0;
        w_cur_raddr = IW'(r_slot);
        w_hist_we = 1'b0;
        w_hist_waddr = IW'(r_count);
        w_hist_wdata = '0;
        w_hist_raddr = IW'(r_idx);
        w_stk_we = 1'b0;
        w_stk_waddr = AW'(r_depth);
        w_stk_wdata = {IW'(r_slot), 32'd0};
        w_stk_raddr = AW'(r_depth - 1'b1);

        if (i_cfg_we) begin
            if (i_cfg_idx) begin
                n_cool = i_cfg_data[15:0];
            end else begin
                n_thr = i_cfg_data;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_req = i_req.req_type;
                    n_tag = i_req.stage_tag;
                    n_t = i_req.elapsed_time;
                    n_idx = '0;
                    case (i_req.req_type)
                        nrtp_pkg::REQ_BEGIN: begin
                            n_depth = '0;
                            if (r_count != '0) begin
                                n_state = S_CLR;
                            end
                        end
                        nrtp_pkg::REQ_ENTER, nrtp_pkg::REQ_RECORD: begin
                            n_state = S_SRD;
                        end
                        nrtp_pkg::REQ_LEAVE: begin
                            if (r_depth == '0) begin
                                n_state = S_SRD;
                            end else begin
                                n_depth = r_depth - 1'b1;
                                n_state = S_POPD;
                            end
                        end
                        nrtp_pkg::REQ_END: begin
                            n_state = S_EFST;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CLR: begin
                w_cur_we = 1'b1;
                w_cur_waddr = IW'(r_idx);
                n_idx = r_idx + 1'b1;
                if (r_idx == r_count - 1'b1) begin
                    n_state = S_IDLE;
                end
            end
            S_SRD: begin
                if (r_idx == r_count) begin
                    if (r_count == SLOT_NONE) begin
                        n_slot = SLOT_NONE;
                    end else begin
                        w_tag_we = 1'b1;
                        w_cur_we = 1'b1;
                        w_cur_waddr = IW'(r_count);
                        w_hist_we = 1'b1;
                        n_slot = r_count;
                        n_count = r_count + 1'b1;
                    end
                    n_state = S_FOUND;
                end else begin
                    n_state = S_SCMP;
                end
            end
            S_SCMP: begin
                if (w_tag_rdata == r_tag) begin
                    n_slot = r_idx;
                    n_state = S_FOUND;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_SRD;
                end
            end
            S_FOUND: begin
                if (r_req == nrtp_pkg::REQ_ENTER) begin
                    if (w_out_free) begin
                        n_out = '0;
                        n_out.stage_slot = nrtp_pkg::t_slot'(r_slot);
                        n_out.stage_id = r_tag;
                        if (r_slot != SLOT_NONE && r_depth != DW'(MAX_DEPTH)) begin
                            n_out.item_kind = nrtp_pkg::KIND_ENTER_OK;
                            w_stk_we = 1'b1;
                            n_depth = r_depth + 1'b1;
                        end else begin
                            n_out.item_kind = nrtp_pkg::KIND_ENTER_NO;
                        end
                        n_out_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (r_slot != SLOT_NONE) begin
                    n_chg_t = r_t;
                    n_chg_s = r_t;
                    n_par = 1'b0;
                    n_state = S_CHG;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_POPD: begin
                n_slot = SW'(w_stk_rdata[KW-1:32]);
                w_cur_raddr = w_stk_rdata[KW-1:32];
                n_chg_t = r_t;
                n_chg_s = w_pchild;
                n_par = (r_depth != '0);
                n_state = S_CHG;
            end
            S_CHG: begin
                w_cur_we = 1'b1;
                w_cur_wdata.total = w_add_t[32] ? 32'hFFFF_FFFF : w_add_t[31:0];
                w_cur_wdata.self_t = w_add_s[32] ? 32'hFFFF_FFFF : w_add_s[31:0];
                w_cur_wdata.calls = (w_cur_rdata.calls == 16'hFFFF) ?
                                    16'hFFFF : w_cur_rdata.calls + 16'd1;
                if (r_par) begin
                    w_stk_we = 1'b1;
                    w_stk_waddr = AW'(r_depth - 1'b1);
                    w_stk_wdata = {w_stk_rdata[KW-1:32], w_sum};
                end
                n_state = S_IDLE;
            end
            S_EFST: begin
                n_fn = r_fn + 32'd1;
                n_first = (r_fn == 32'd0);
                n_favg = (r_fn == 32'd0) ? r_t : w_bl_f;
                n_fpeak = (r_t > r_fpeak) ? r_t : r_fpeak;
                n_depth = '0;
                n_hs = SLOT_NONE;
                n_hi = SLOT_NONE;
                n_hs_t = '0;
                n_hi_t = '0;
                n_state = (r_count != '0) ? S_EFRD : S_EFSUM;
            end
            S_EFRD: begin
                w_cur_raddr = IW'(r_idx);
                n_state = S_EFCALC;
            end
            S_EFCALC: begin
                w_cur_raddr = IW'(r_idx);
                if (w_out_free) begin
                    w_hist_we = 1'b1;
                    w_hist_waddr = IW'(r_idx);
                    w_hist_wdata = w_hist_new;
                    if (w_cur_rdata.self_t > r_hs_t) begin
                        n_hs_t = w_cur_rdata.self_t;
                        n_hs = r_idx;
                    end
                    if (w_cur_rdata.total > r_hi_t) begin
                        n_hi_t = w_cur_rdata.total;
                        n_hi = r_idx;
                    end
                    n_out.item_kind = nrtp_pkg::KIND_REPORT;
                    n_out.stage_slot = nrtp_pkg::t_slot'(r_idx);
                    n_out.stage_id = w_tag_rdata;
                    n_out.total_last = w_cur_rdata.total;
                    n_out.self_last = w_cur_rdata.self_t;
                    n_out.total_avg = w_hist_new.avg_total;
                    n_out.self_avg = w_hist_new.avg_self;
                    n_out.total_max = w_hist_new.peak_total;
                    n_out.self_max = w_hist_new.peak_self;
                    n_out.count_value = {16'd0, w_cur_rdata.calls};
                    n_out.slow_frame = 1'b0;
                    n_out.last_result = 1'b0;
                    n_out_valid = 1'b1;
                    n_idx = r_idx + 1'b1;
                    n_state = (r_idx == r_count - 1'b1) ? S_EFSUM : S_EFRD;
                end
            end
            S_EFSUM: begin
                if (w_out_free) begin
                    n_out.item_kind = nrtp_pkg::KIND_SUMMARY;
                    n_out.stage_slot = nrtp_pkg::t_slot'(r_hs);
                    n_out.stage_id = 16'(r_hi);
                    n_out.total_last = r_t;
                    n_out.self_last = r_hs_t;
                    n_out.total_avg = r_favg;
                    n_out.self_avg = '0;
                    n_out.total_max = r_fpeak;
                    n_out.self_max = r_hi_t;
                    n_out.count_value = r_fn;
                    n_out.slow_frame = w_flag;
                    n_out.last_result = 1'b1;
                    n_out_valid = 1'b1;
                    if (w_flag) begin
                        n_lsf = r_fn;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_depth <= '0;
            r_fn <= '0;
            r_favg <= '0;
            r_fpeak <= '0;
            r_lsf <= '0;
            r_thr <= 32'd51200;
            r_cool <= 16'd60;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_depth <= n_depth;
            r_fn <= n_fn;
            r_favg <= n_favg;
            r_fpeak <= n_fpeak;
            r_lsf <= n_lsf;
            r_thr <= n_thr;
            r_cool <= n_cool;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_tag <= n_tag;
        r_t <= n_t;
        r_idx <= n_idx;
        r_slot <= n_slot;
        r_chg_t <= n_chg_t;
        r_chg_s <= n_chg_s;
        r_par <= n_par;
        r_first <= n_first;
        r_hs <= n_hs;
        r_hi <= n_hi;
        r_hs_t <= n_hs_t;
        r_hi_t <= n_hi_t;
        r_out <= n_out;
    end

    assign o_res.valid = r_out_valid;
    assign o_res.item_kind = r_out.item_kind;
    assign o_res.stage_slot = r_out.stage_slot;
    assign o_res.stage_id = r_out.stage_id;
    assign o_res.total_last = r_out.total_last;
    assign o_res.self_last = r_out.self_last;
    assign o_res.total_avg = r_out.total_avg;
    assign o_res.self_avg = r_out.self_avg;
    assign o_res.total_max = r_out.total_max;
    assign o_res.self_max = r_out.self_max;
    assign o_res.count_value = r_out.count_value;
    assign o_res.slow_frame = r_out.slow_frame;
    assign o_res.last_result = r_out.last_result;

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(MAX_DEPTH))
        else $error("region stack depth beyond its capacity");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SLOT_NONE)
        else $error("stage count beyond the table size");
    a_last_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last_result) |-> (r_out.item_kind == nrtp_pkg::KIND_SUMMARY))
        else $error("last transaction flag on a result other than the summary");
`endif
endmodule

>>> hw/rtl/nrtp_ram.sv
// Simple dual-port synchronous memory with registered read.
// No dependencies.
module nrtp_ram #(
    parameter int W = 32,
    parameter int D = 32
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                  i_wdata,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                  o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/nrtp_blend.sv
// Running average step, asymmetric through the caller's choice of f: cur moves toward tgt by f/1024, rounded.
// Uses a 32 by 8 multiply; no dependencies.
module nrtp_blend (
    input  logic [31:0] i_cur,
    input  logic [31:0] i_tgt,
    input  logic [7:0]  i_f,
    output logic [31:0] o_avg
);
    logic        w_up;
    logic [31:0] w_d;
    logic [40:0] w_p;
    logic [31:0] w_q;

    always_comb begin
        w_up = (i_tgt >= i_cur);
        w_d = w_up ? (i_tgt - i_cur) : (i_cur - i_tgt);
        w_p = 41'(w_d) * 41'(i_f) + 41'd512;
        w_q = 32'(w_p[40:10]);
        o_avg = w_up ? (i_cur + w_q) : (i_cur - w_q);
    end
endmodule
